// ===== rtl/core/isr_pkg.sv =====
// Package for the indexed set with swap-remove.
// Holds the operation and status codes, field widths and the beat structs.
// No dependencies.
package isr_pkg;

    localparam int KEY_W    = 32;
    localparam int DRAW_W   = 16;
    localparam int POS_W    = 6;
    localparam int STEP_W   = $clog2(DRAW_W);
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        F_ADD    = 2'd0,
        F_REMOVE = 2'd1,
        F_SEARCH = 2'd2,
        F_PICK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NOCHG  = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [KEY_W-1:0]   key;
        logic [DRAW_W-1:0]         random_draw;
    } t_isr_in;

    typedef struct packed {
        t_status                   status;
        logic                      found;
        logic [POS_W-1:0]          position;
        logic signed [KEY_W-1:0]   value;
    } t_isr_out;

endpackage

// ===== rtl/core/indexed_set_swap_remove_unit.sv =====
// Top level of the indexed set with swap-remove.
// Depends on isr_pkg and isr_ram.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Each command gives exactly one result beat, shown on o_out and marked by o_done
// for one cycle; the receiver cannot stall it, so it must take it then.
// Keys live in one RAM with a registered read, packed in slots
// below the entry count. Add, remove and search read the slots one per cycle
// and compare each with the key; a remove that hits a key below the last slot
// then moves the last key into the freed slot. A random pick reduces the draw
// modulo the count in a one-bit-per-cycle restoring divider and then reads the
// slot. A pick on an empty store answers in the cycle after the command is
// taken. busy falls in the
// cycle in which the result is strobed, so the next command can be taken then.
// Reset clears the entry count and the control state; the RAM is not cleared,
// since only slots below the count are ever read.
module indexed_set_swap_remove_unit
    import isr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_isr_in  i_in,
    output logic     o_done,
    output t_isr_out o_out
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_MVRD = 7'b0000100,
        S_MVWR = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_PRD  = 7'b0100000,
        S_PRSP = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_done,  n_done;
    logic [CW-1:0]       r_idx,   n_idx;
    logic                r_pend,  n_pend;
    logic [IW-1:0]       r_pos,   n_pos;
    logic [CW-1:0]       r_rem,   n_rem;
    logic [STEP_W-1:0]   r_step,  n_step;
    t_func               r_func,  n_func;
    logic [KEY_W-1:0]    r_key,   n_key;
    logic [DRAW_W-1:0]   r_draw,  n_draw;
    t_isr_out            r_out,   n_out;

    logic                we;
    logic [IW-1:0]       waddr;
    logic [KEY_W-1:0]    wdata;
    logic [IW-1:0]       raddr;
    logic [KEY_W-1:0]    rd_data;
    logic                hit;
    logic                issue;
    logic [IW-1:0]       last;
    logic [CW:0]         rem_sh;

    function automatic t_isr_out make_out(t_status st, logic fnd, logic [IW-1:0] pos,
                                          logic [KEY_W-1:0] val);
        t_isr_out o;
        o.status   = st;
        o.found    = fnd;
        o.position = POS_W'(pos);
        o.value    = val;
        return o;
    endfunction

    isr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign hit    = r_pend && (rd_data == r_key);
    assign issue  = r_idx < r_count;
    assign last   = IW'(r_count - 1'b1);
    assign rem_sh = {r_rem, r_draw[DRAW_W-1]};

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_pos   = r_pos;
        n_rem   = r_rem;
        n_step  = r_step;
        n_func  = r_func;
        n_key   = r_key;
        n_draw  = r_draw;
        n_out   = r_out;
        we      = 1'b0;
        waddr   = r_count[IW-1:0];
        wdata   = r_key;
        raddr   = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = i_in.func;
                    n_key  = i_in.key;
                    n_draw = i_in.random_draw;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_rem  = '0;
                    n_step = '0;
                    if (i_in.func == F_PICK) begin
                        if (r_count == '0) begin
                            n_done = 1'b1;
                            n_out  = make_out(ST_EMPTY, 1'b0, '0, '0);
                        end else begin
                            n_state = S_DIV;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    case (r_func)
                        F_ADD: begin
                            n_done  = 1'b1;
                            n_out   = make_out(ST_NOCHG, 1'b1, r_pos, '0);
                            n_state = S_IDLE;
                        end
                        F_REMOVE: begin
                            if (r_pos == last) begin
                                n_count = r_count - 1'b1;
                                n_done  = 1'b1;
                                n_out   = make_out(ST_DONE, 1'b1, r_pos, '0);
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_MVRD;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_out   = make_out(ST_DONE, 1'b1, r_pos, '0);
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (!issue) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_func == F_ADD) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_out = make_out(ST_FULL, 1'b0, '0, '0);
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + 1'b1;
                            n_out   = make_out(ST_DONE, 1'b0, '0, '0);
                        end
                    end else begin
                        n_out = make_out(ST_NOCHG, 1'b0, '0, '0);
                    end
                end else begin
                    n_pend = 1'b1;
                    n_pos  = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_MVRD: begin
                raddr   = last;
                n_state = S_MVWR;
            end
            S_MVWR: begin
                we      = 1'b1;
                waddr   = r_pos;
                wdata   = rd_data;
                n_count = r_count - 1'b1;
                n_done  = 1'b1;
                n_out   = make_out(ST_DONE, 1'b1, r_pos, '0);
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_count}) begin
                    n_rem = CW'(rem_sh - {1'b0, r_count});
                end else begin
                    n_rem = CW'(rem_sh);
                end
                n_draw = {r_draw[DRAW_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DRAW_W - 1)) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                raddr   = r_rem[IW-1:0];
                n_state = S_PRSP;
            end
            S_PRSP: begin
                n_done  = 1'b1;
                n_out   = make_out(ST_DONE, 1'b1, r_rem[IW-1:0], rd_data);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_func <= n_func;
        r_key  <= n_key;
        r_draw <= n_draw;
        r_out  <= n_out;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result strobe without a command in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.func != F_PICK)) |=> busy)
        else $error("search command not started after acceptance");

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_out.status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("store full reported below capacity");
`endif

endmodule

// ===== rtl/core/isr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module isr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
